// ----- hdl/sorted_key_run_lookup_macros.svh -----
// Assertion macros used by the sorted key run lookup top level.
`ifndef SORTED_KEY_RUN_LOOKUP_MACROS_SVH
`define SORTED_KEY_RUN_LOOKUP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SKRL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SKRL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/skrl_pkg.sv -----
// Types and constants shared by the sorted key run lookup cells and top level.
package skrl_pkg;

    localparam int KEY_W  = 31;
    localparam int VAL_W  = 31;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int RUN_W  = 7;

    // Operation codes carried in the input tuser
    localparam logic [KIND_W-1:0] K_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] K_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] K_QUERY  = 2'd2;

    // Result status codes carried in the output tuser
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_INSERT,
        OP_PROBE,
        OP_SHIFT
    } t_cell_op;

    // Broadcast command to every cell
    typedef struct packed {
        t_cell_op          op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_cell_ctl;

    // Contents and insert decision handed to the right-hand neighbour
    typedef struct packed {
        logic              take;
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_cell_link;

    // Probe copy handed to the left-hand neighbour during a query scan
    typedef struct packed {
        logic              hit;
        logic [VAL_W-1:0]  value;
    } t_probe;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

// ----- hdl/skrl_cell.sv -----
// One cell of the sorted table: holds an entry, shifts on insert, probes on query.
module skrl_cell
    import skrl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_link i_left,
    input  t_probe     i_probe_right,
    output t_cell_link o_link,
    output t_probe     o_probe,
    output logic       o_lt,
    output logic       o_le
);

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_lt, n_lt;
    logic             r_le, n_le;
    logic             r_probe_hit;
    logic [VAL_W-1:0] r_probe_value;
    t_probe           n_probe;
    logic             w_take;

    // This cell lies at or after the insert point when empty or holding a larger key
    assign w_take = !r_valid || (r_key > i_ctl.key);

    always_comb begin
        n_valid       = r_valid;
        n_key         = r_key;
        n_value       = r_value;
        n_lt          = r_lt;
        n_le          = r_le;
        n_probe.hit   = r_probe_hit;
        n_probe.value = r_probe_value;
        case (i_ctl.op)
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_INSERT: begin
                if (w_take) begin
                    if (i_left.take) begin
                        // shift the neighbour's entry one place right
                        n_valid = i_left.valid;
                        n_key   = i_left.key;
                        n_value = i_left.value;
                    end else begin
                        // first cell past the insert point takes the new pair
                        n_valid = 1'b1;
                        n_key   = i_ctl.key;
                        n_value = i_ctl.value;
                    end
                end
            end
            OP_PROBE: begin
                n_lt          = r_valid && (r_key < i_ctl.key);
                n_le          = r_valid && (r_key <= i_ctl.key);
                n_probe.hit   = r_valid && (r_key == i_ctl.key);
                n_probe.value = r_value;
            end
            OP_SHIFT: begin
                n_probe = i_probe_right;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_lt        <= 1'b0;
            r_le        <= 1'b0;
            r_probe_hit <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_lt        <= n_lt;
            r_le        <= n_le;
            r_probe_hit <= n_probe.hit;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_value       <= n_value;
        r_probe_value <= n_probe.value;
    end

    assign o_link.take   = w_take;
    assign o_link.valid  = r_valid;
    assign o_link.key    = r_key;
    assign o_link.value  = r_value;
    assign o_probe.hit   = r_probe_hit;
    assign o_probe.value = r_probe_value;
    assign o_lt          = r_lt;
    assign o_le          = r_le;

endmodule

// ----- hdl/sorted_key_run_lookup.sv -----
// Sorted key/value table in a chain of cells; clear, stable insert and run query.
// Clear and insert: result registered at the accepting edge.
// Query: the cells probe first, then the probe copies shift one cell per cycle toward
//   cell 0; a miss gives one not-found result.
// Throughput is set by that probe shift chain; output stalls pause the scan only at a match.
// Synchronous active-low reset empties the table and idles the control.
module sorted_key_run_lookup
    import skrl_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // key[30:0], value[61:31], zero[63:62]
    input  logic [1:0]  i_s_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // value_res[30:0], run_length[37:31], zero[39:38]
    output logic [1:0]  o_m_axis_tuser,  // status[1:0]
    output logic        o_m_axis_tlast   // last
);

    `include "sorted_key_run_lookup_macros.svh"

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Count the ones of a prefix-filled flag vector by binary search
    function automatic logic [CW-1:0] f_count(input logic [DEPTH-1:0] t);
        logic [CW-1:0] c;
        logic [CW-1:0] cand;
        c = '0;
        for (int b = CW - 1; b >= 0; b--) begin
            cand = c | (CW'(1) << b);
            if (cand <= CW'(DEPTH)) begin
                if (t[IW'(cand - 1'b1)]) begin
                    c = cand;
                end
            end
        end
        return c;
    endfunction

    t_cell_ctl          w_ctl;
    t_cell_link         w_link  [DEPTH];
    t_probe             w_probe [DEPTH];
    logic [DEPTH-1:0]   v_valid, v_lt, v_le;
    logic [CW-1:0]      v_run;
    logic               w_full, w_in_acc, w_out_free;
    logic [KIND_W-1:0]  w_kind;
    logic [KEY_W-1:0]   w_key;
    logic [VAL_W-1:0]   w_value;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_sent, n_sent;
    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [VAL_W-1:0]   r_out_value, n_out_value;
    logic [RUN_W-1:0]   r_out_run, n_out_run;
    logic               r_out_last, n_out_last;

    // Unpack the input transaction
    assign w_kind  = i_s_axis_tuser;
    assign w_key   = i_s_axis_tdata[KEY_W-1:0];
    assign w_value = i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];

    // Build the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link w_left;
        t_probe     w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_rest
            assign w_left = w_link[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_probe[g+1];
        end
        skrl_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left        (w_left),
            .i_probe_right (w_right),
            .o_link        (w_link[g]),
            .o_probe       (w_probe[g]),
            .o_lt          (v_lt[g]),
            .o_le          (v_le[g])
        );
        assign v_valid[g] = w_link[g].valid;
    end

    // Run length from the lower and upper bound prefixes
    assign v_run      = f_count(v_le) - f_count(v_lt);
    assign w_full     = v_valid[DEPTH-1];
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    // Sequence operations and load the output register
    always_comb begin
        n_state      = r_state;
        n_sent       = r_sent;
        w_ctl.op     = OP_HOLD;
        w_ctl.key    = w_key;
        w_ctl.value  = w_value;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_run    = r_out_run;
        n_out_last   = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (w_kind)
                        K_CLEAR: begin
                            w_ctl.op     = OP_CLEAR;
                            n_out_valid  = 1'b1;
                            n_out_status = ST_OK;
                            n_out_value  = '0;
                            n_out_run    = '0;
                            n_out_last   = 1'b1;
                        end
                        K_INSERT: begin
                            if (!w_full) begin
                                w_ctl.op = OP_INSERT;
                            end
                            n_out_valid  = 1'b1;
                            n_out_status = w_full ? ST_FULL : ST_OK;
                            n_out_value  = '0;
                            n_out_run    = '0;
                            n_out_last   = 1'b1;
                        end
                        K_QUERY: begin
                            w_ctl.op = OP_PROBE;
                            n_sent   = '0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (v_run == '0) begin
                    // no match: one not-found result
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NOT_FOUND;
                        n_out_value  = '0;
                        n_out_run    = '0;
                        n_out_last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (w_probe[0].hit) begin
                    // emit the matching value at the head, then advance
                    if (w_out_free) begin
                        w_ctl.op     = OP_SHIFT;
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OK;
                        n_out_value  = w_probe[0].value;
                        n_out_run    = RUN_W'(v_run);
                        n_out_last   = (r_sent + 1'b1) == v_run;
                        n_sent       = r_sent + 1'b1;
                        if ((r_sent + 1'b1) == v_run) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    // drop a non-matching head entry
                    w_ctl.op = OP_SHIFT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sent      <= n_sent;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_run    <= n_out_run;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_run, r_out_value};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    `SKRL_ASSERT_IMP(a_valid_prefix, 1'b1, ((v_valid >> 1) & ~v_valid) == '0,
        "occupied cells are not a contiguous prefix")
    `SKRL_ASSERT_IMP(a_bounds_order, r_state == S_SCAN, (v_lt & ~v_le) == '0,
        "lower bound lies beyond upper bound")
    `SKRL_ASSERT_IMP(a_sent_in_run, (r_state == S_SCAN) && (v_run != '0), r_sent < v_run,
        "more results sent than the run holds")
    `SKRL_ASSERT_NXT(a_full_drop, w_in_acc && (w_kind == K_INSERT) && w_full,
        $stable(v_valid), "insert into a full table changed the occupancy")

endmodule
